// ----- sv/uns_pkg.sv -----
// Shared constants and types for the UTF-8 name sanitizer.
package uns_pkg;

   localparam int NAME_CAPACITY = 64;
   localparam logic [6:0] CAP_W = 7'(NAME_CAPACITY);
   localparam int BURST_MAX = 4;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_QMARK    = 8'h3f;
   localparam logic [7:0] CH_DEL      = 8'h7f;
   localparam logic [7:0] LEAD_MIN    = 8'hc2;
   localparam logic [7:0] LEAD2_MAX   = 8'hdf;
   localparam logic [7:0] LEAD3_MAX   = 8'hef;
   localparam logic [7:0] LEAD_MAX    = 8'hf4;
   localparam logic [7:0] LEAD_E0     = 8'he0;
   localparam logic [7:0] LEAD_ED     = 8'hed;
   localparam logic [7:0] LEAD_F0     = 8'hf0;
   localparam logic [7:0] LEAD_F4     = 8'hf4;
   localparam logic [7:0] CONT_A0     = 8'ha0;
   localparam logic [7:0] CONT_90     = 8'h90;
   localparam logic [1:0] CONT_TAG    = 2'b10;

   typedef struct packed {
      logic [7:0] data;
      logic [5:0] pos;
      logic       done;
   } entry_type;

   typedef struct packed {
      entry_type [BURST_MAX-1:0] ents;
      logic [2:0]                count;
   } burst_type;

endpackage

// ----- sv/uns_engine.sv -----
// Name state and per-byte result generation for the UTF-8 name sanitizer.
module uns_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   output uns_pkg::burst_type burst
);
   import uns_pkg::*;

   typedef struct packed {
      entry_type [BURST_MAX-1:0] ents;
      logic [2:0]                n;
      logic [5:0]                u;
      logic [5:0]                t;
      logic                      f;
   } gen_type;

   logic [5:0] used_ff, used_in;
   logic [5:0] trim_ff, trim_in;
   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] pc_ff, pc_in;
   logic [2:0] exp_ff, exp_in;
   logic       full_ff, full_in;

   gen_type    g;
   logic       cont;
   logic       bad;

   function automatic gen_type put_byte(gen_type gi, logic [7:0] b);
      gen_type r;
      r = gi;
      if (gi.f || ({1'b0, gi.u} + 7'd1 >= CAP_W)) begin
         r.f = 1'b1;
      end else begin
         r.ents[gi.n[1:0]] = '{data: b, pos: gi.u, done: 1'b0};
         r.u = gi.u + 6'd1;
         if (b != CH_SPACE) begin
            r.t = gi.u + 6'd1;
         end
         r.n = gi.n + 3'd1;
      end
      return r;
   endfunction

   always_comb begin
      cont = (in_byte[7:6] == CONT_TAG);
      bad  = ((pend_ff[0] == LEAD_E0) && (in_byte < CONT_A0)) ||
             ((pend_ff[0] == LEAD_ED) && (in_byte >= CONT_A0)) ||
             ((pend_ff[0] == LEAD_F0) && (in_byte < CONT_90)) ||
             ((pend_ff[0] == LEAD_F4) && (in_byte >= CONT_90));
      g      = '0;
      g.u    = used_ff;
      g.t    = trim_ff;
      g.f    = full_ff;
      pend_in = pend_ff;
      pc_in  = pc_ff;
      exp_in = exp_ff;
      if ((pc_ff != 2'd0) && cont) begin
         if ((pc_ff == 2'd1) && bad) begin
            g = put_byte(g, CH_QMARK);
            g = put_byte(g, CH_QMARK);
            pc_in  = 2'd0;
            exp_in = 3'd0;
         end else if ({1'b0, pc_ff} + 3'd1 >= exp_ff) begin
            if ({1'b0, used_ff} + {4'b0, exp_ff} >= CAP_W) begin
               g.f = 1'b1;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < pc_ff) begin
                     g = put_byte(g, pend_ff[k]);
                  end
               end
               g = put_byte(g, in_byte);
            end
            pc_in  = 2'd0;
            exp_in = 3'd0;
         end else begin
            pend_in[pc_ff] = in_byte;
            pc_in = pc_ff + 2'd1;
         end
      end else begin
         if (pc_ff != 2'd0) begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) < pc_ff) begin
                  g = put_byte(g, CH_QMARK);
               end
            end
            pc_in  = 2'd0;
            exp_in = 3'd0;
         end
         if (in_byte == CH_NUL) begin
            g.ents[g.n[1:0]] = '{data: CH_NUL, pos: g.t, done: 1'b1};
            g.n    = g.n + 3'd1;
            g.u    = 6'd0;
            g.t    = 6'd0;
            g.f    = 1'b0;
            pc_in  = 2'd0;
            exp_in = 3'd0;
         end else if (g.f || ({1'b0, g.u} + 7'd1 >= CAP_W)) begin
            g.f = 1'b1;
         end else if (in_byte < 8'h80) begin
            if ((in_byte < CH_SPACE) || (in_byte == CH_DEL)) begin
               g = put_byte(g, CH_SPACE);
            end else begin
               g = put_byte(g, in_byte);
            end
         end else if ((in_byte >= LEAD_MIN) && (in_byte <= LEAD_MAX)) begin
            pend_in[0] = in_byte;
            pc_in = 2'd1;
            if (in_byte <= LEAD2_MAX) begin
               exp_in = 3'd2;
            end else if (in_byte <= LEAD3_MAX) begin
               exp_in = 3'd3;
            end else begin
               exp_in = 3'd4;
            end
         end else begin
            g = put_byte(g, CH_QMARK);
         end
      end
      used_in = g.u;
      trim_in = g.t;
      full_in = g.f;
      burst.ents  = g.ents;
      burst.count = g.n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 6'd0;
         trim_ff <= 6'd0;
         pc_ff   <= 2'd0;
         exp_ff  <= 3'd0;
         full_ff <= 1'b0;
      end else if (accept) begin
         used_ff <= used_in;
         trim_ff <= trim_in;
         pc_ff   <= pc_in;
         exp_ff  <= exp_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

// ----- sv/utf8_name_sanitizer.sv -----
// Top level of the UTF-8 name sanitizer: engine, result buffer and output register.
//
// Name bytes arrive one per transaction; a zero byte ends the name and yields one end
// transaction carrying the trimmed length. A byte yields zero to four result transactions:
// ordinary bytes give one, a byte that completes a multi-byte character or breaks a
// buffered sequence gives up to four. Results leave one per cycle, rsp_stall permitting,
// from a four-entry result buffer behind the engine. The input is stalled until that buffer
// has drained its last entry: one byte per cycle while each gives at most one result and
// rsp_stall is low, else the input waits for the results to drain. An output register parts
// the result side from the input side. No clearing pass follows reset.
module utf8_name_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [5:0] rsp_position,
   output logic       rsp_name_done,
   output logic [5:0] rsp_final_length,
   output logic       rsp_needs_fallback
);
   import uns_pkg::*;

   burst_type                  burst;
   entry_type [BURST_MAX-1:0]  ents_ff, ents_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [1:0]                 rd_ff, rd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 out_byte_ff;
   logic [5:0]                 position_ff;
   logic                       name_done_ff;
   logic [5:0]                 final_length_ff;
   logic                       needs_fallback_ff;
   logic                       move;
   logic                       accept;
   entry_type                  head;

   uns_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .burst   (burst)
   );

   always_comb begin
      move      = (cnt_ff != 3'd0) && (!rsp_valid_ff || !rsp_stall);
      req_stall = !((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && move));
      accept    = req_valid && !req_stall;
      head      = ents_ff[rd_ff];
      ents_in   = accept ? burst.ents : ents_ff;
      if (accept) begin
         cnt_in = burst.count;
         rd_in  = 2'd0;
      end else if (move) begin
         cnt_in = cnt_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end else begin
         cnt_in = cnt_ff;
         rd_in  = rd_ff;
      end
      rsp_valid_in = move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd0;
         rd_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ents_ff <= ents_in;
      if (move) begin
         out_byte_ff       <= head.data;
         position_ff       <= head.pos;
         name_done_ff      <= head.done;
         final_length_ff   <= head.done ? head.pos : 6'd0;
         needs_fallback_ff <= head.done && (head.pos == 6'd0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_position       = position_ff;
   assign rsp_name_done      = name_done_ff;
   assign rsp_final_length   = final_length_ff;
   assign rsp_needs_fallback = needs_fallback_ff;

endmodule
